/* hdl/tda_pkg.sv */
// shared types, constants and the decay table for the time decayed average
package tda_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int EXP_TABLE_BITS = 8;
  localparam int TIME_WIDTH     = 32;
  localparam int HL_WIDTH       = 16;
  localparam int AVG_WIDTH      = 32;
  localparam int FRAC_BITS      = 16;

  localparam int ROM_SIZE   = 1 << EXP_TABLE_BITS;
  localparam int ROM_WIDTH  = FRAC_BITS + 1;
  localparam int SHIFT_BITS = $clog2(FRAC_BITS);

  // dividend is elapsed time with the table index bits appended
  localparam int DIV_WIDTH = TIME_WIDTH + EXP_TABLE_BITS;
  localparam int CNT_WIDTH = $clog2(DIV_WIDTH);

  // target = sample in Q.16, diff = avg - target, product = factor * diff
  localparam int TARGET_WIDTH = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DIFF_WIDTH   = TARGET_WIDTH + 1;
  localparam int PROD_WIDTH   = DIFF_WIDTH + ROM_WIDTH + 1;
  localparam int SHR_WIDTH    = PROD_WIDTH - FRAC_BITS;
  localparam int SUM_WIDTH    = SHR_WIDTH + 1;

  typedef logic [ROM_WIDTH-1:0] rom_t [ROM_SIZE];

  typedef struct packed {
    logic load;
    logic div_step;
    logic factor_en;
    logic mul_en;
    logic sum_en;
  } cmd_t;

  typedef struct packed {
    logic hl_zero;
  } status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_w;
    x = x_in;
    res = 64'd0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) begin
      bit_w = bit_w >> 2;
    end
    while (bit_w != 64'd0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // entry f is 2^(-f/ROM_SIZE) in Q1.16, built from repeated square roots
  function automatic rom_t build_rom();
    logic [63:0] roots [EXP_TABLE_BITS+1];
    logic [63:0] acc;
    logic [63:0] rnd;
    rom_t rom;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= EXP_TABLE_BITS; k++) begin
      roots[k] = isqrt64(roots[k-1] << 32);
    end
    for (int i = 0; i < ROM_SIZE; i++) begin
      acc = 64'd1 << 32;
      for (int j = 0; j < EXP_TABLE_BITS; j++) begin
        if (((i >> j) & 1) != 0) begin
          acc = (acc * roots[EXP_TABLE_BITS - j]) >> 32;
        end
      end
      rnd = acc + 64'h8000;
      rom[i] = rnd[FRAC_BITS +: ROM_WIDTH];
    end
    return rom;
  endfunction

  localparam rom_t DECAY_ROM = build_rom();

endpackage

/* hdl/tda_ctrl.sv */
// controller for the time decayed average: sequences division, factor, multiply and update
module tda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tda_pkg::status_t  status,
  output tda_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FACT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;

  localparam logic [tda_pkg::CNT_WIDTH-1:0] LAST_STEP =
    tda_pkg::CNT_WIDTH'(tda_pkg::DIV_WIDTH - 1);

  logic [2:0] state;
  logic [2:0] state_next;
  logic [tda_pkg::CNT_WIDTH-1:0] cnt;
  logic sum_fire;

  assign in_ready = (state == S_IDLE);
  // the update waits until the output register is free
  assign sum_fire = (state == S_SUM) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.load      = in_valid && in_ready;
    cmd.div_step  = (state == S_DIV);
    cmd.factor_en = (state == S_FACT);
    cmd.mul_en    = (state == S_MUL);
    cmd.sum_en    = sum_fire;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.hl_zero ? S_SUM : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == LAST_STEP) begin
          state_next = S_FACT;
        end
      end
      S_FACT: state_next = S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM: begin
        if (sum_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (sum_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DIV || state == S_SUM))
    else $error("accepted item did not start processing");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= LAST_STEP))
    else $error("division step counter overran");

  a_sum_free: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_en |-> (!out_valid || out_ready))
    else $error("result written over an item not yet taken");

  a_sum_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_en |=> (out_valid && state == S_IDLE))
    else $error("result not presented after update");
`endif

endmodule

/* hdl/tda_datapath.sv */
// datapath for the time decayed average: serial divider, decay table, multiply and saturating update
module tda_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tda_pkg::HL_WIDTH-1:0]        half_life_ms,
  input  logic signed [15:0]                  sample,
  input  logic [tda_pkg::TIME_WIDTH-1:0]      timestamp_ms,
  input  tda_pkg::cmd_t                       cmd,
  output tda_pkg::status_t                    status,
  output logic signed [tda_pkg::AVG_WIDTH-1:0] average
);

  localparam int SW  = tda_pkg::SAMPLE_WIDTH;
  localparam int ETB = tda_pkg::EXP_TABLE_BITS;
  localparam int HW  = tda_pkg::HL_WIDTH;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  logic [HW-1:0] half_life;
  logic signed [tda_pkg::AVG_WIDTH-1:0] avg;
  logic [tda_pkg::TIME_WIDTH-1:0] last_time;
  logic [tda_pkg::TIME_WIDTH-1:0] ts;
  logic signed [SW-1:0] samp;

  logic [HW-1:0] rem;
  logic [tda_pkg::DIV_WIDTH-1:0] dq;
  logic [tda_pkg::ROM_WIDTH-1:0] factor;
  logic signed [tda_pkg::DIFF_WIDTH-1:0] diff;
  logic signed [tda_pkg::PROD_WIDTH-1:0] prod;

  logic [HW:0] rem_shift;
  logic        q_bit;
  logic [tda_pkg::TIME_WIDTH-1:0] elapsed;
  logic [tda_pkg::TIME_WIDTH-1:0] whole;
  logic [ETB-1:0] frac;
  logic [tda_pkg::SHIFT_BITS-1:0] shamt;
  logic signed [tda_pkg::TARGET_WIDTH-1:0] target;
  logic signed [tda_pkg::SUM_WIDTH-1:0] sum;
  logic signed [63:0] sum_wide;
  logic signed [tda_pkg::AVG_WIDTH-1:0] avg_next;

  assign status.hl_zero = (half_life == '0);
  assign elapsed = timestamp_ms - last_time;

  // restoring division, one quotient bit per step, quotient shifts into dq
  assign rem_shift = {rem, dq[tda_pkg::DIV_WIDTH-1]};
  assign q_bit = (rem_shift >= {1'b0, half_life});

  assign whole = dq[tda_pkg::DIV_WIDTH-1:ETB];
  assign frac  = dq[ETB-1:0];
  assign shamt = dq[ETB +: tda_pkg::SHIFT_BITS];

  assign target = {samp, {tda_pkg::FRAC_BITS{1'b0}}};

  always_comb begin
    if (status.hl_zero) begin
      sum = tda_pkg::SUM_WIDTH'(target);
    end else begin
      sum = tda_pkg::SUM_WIDTH'(target)
          + tda_pkg::SUM_WIDTH'($signed(prod[tda_pkg::PROD_WIDTH-1:tda_pkg::FRAC_BITS]));
    end
    sum_wide = {{(64 - tda_pkg::SUM_WIDTH){sum[tda_pkg::SUM_WIDTH-1]}}, sum};
    priority if (sum_wide > SAT_MAX) begin
      avg_next = SAT_MAX[tda_pkg::AVG_WIDTH-1:0];
    end else if (sum_wide < SAT_MIN) begin
      avg_next = SAT_MIN[tda_pkg::AVG_WIDTH-1:0];
    end else begin
      avg_next = sum_wide[tda_pkg::AVG_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_life <= '0;
      avg       <= '0;
      last_time <= '0;
    end else begin
      if (cfg_valid) begin
        half_life <= half_life_ms;
      end
      if (cmd.sum_en) begin
        avg <= avg_next;
        // a zero half life leaves the time reference where it was
        if (!status.hl_zero) begin
          last_time <= ts;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp <= sample[SW-1:0];
      ts   <= timestamp_ms;
      rem  <= '0;
      dq   <= {elapsed, {ETB{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= q_bit ? HW'(rem_shift - {1'b0, half_life}) : rem_shift[HW-1:0];
      dq  <= {dq[tda_pkg::DIV_WIDTH-2:0], q_bit};
    end
    if (cmd.factor_en) begin
      if (whole < tda_pkg::TIME_WIDTH'(tda_pkg::FRAC_BITS)) begin
        factor <= tda_pkg::DECAY_ROM[frac] >> shamt;
      end else begin
        factor <= '0;
      end
      diff <= tda_pkg::DIFF_WIDTH'(avg) - tda_pkg::DIFF_WIDTH'(target);
    end
    if (cmd.mul_en) begin
      prod <= $signed({1'b0, factor}) * diff;
    end
    if (cmd.sum_en) begin
      average <= avg_next;
    end
  end

endmodule

/* hdl/time_decayed_average.sv */
// from item accept to result valid an item passes 40 divider steps, the table lookup, the multiply and the update
// with a zero half life no division runs and the item goes straight from accept to the update
// items are taken one at a time, after the update of the last, paced by the one-bit-per-cycle 40-step serial divider
// a new item is taken while the previous result waits; the update stalls until it is taken
// reset (rst, synchronous): half life, running average and last timestamp clear to zero
module time_decayed_average (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tda_pkg::HL_WIDTH-1:0]         half_life_ms,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   sample,
  input  logic [tda_pkg::TIME_WIDTH-1:0]       timestamp_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tda_pkg::AVG_WIDTH-1:0] average
);

  tda_pkg::cmd_t    cmd;
  tda_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tda_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .half_life_ms (half_life_ms),
    .sample       (sample),
    .timestamp_ms (timestamp_ms),
    .cmd          (cmd),
    .status       (status),
    .average      (average)
  );

endmodule
